@@ rtl/core/csd_pkg.sv @@
// Shared types, codes and constants of the clock and stopwatch display block.
package csd_pkg;

  // Tick rate of the time-of-day clock and the width of its tick counter.
  localparam int unsigned TicksPerSecond = 100;
  localparam int unsigned TickW = $clog2(TicksPerSecond);

  // Reset values of the time-of-day clock.
  localparam logic [5:0] SecondsReset = 6'd45;
  localparam logic [5:0] MinutesReset = 6'd59;
  localparam logic [4:0] HoursReset   = 5'd23;

  // Command codes of an input item.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // Key codes that act; all others are ignored.
  localparam logic [3:0] KEY_HOUR_UP  = 4'd8;
  localparam logic [3:0] KEY_MIN_UP   = 4'd9;
  localparam logic [3:0] KEY_SHOW_SW  = 4'd10;
  localparam logic [3:0] KEY_START    = 4'd11;
  localparam logic [3:0] KEY_HOUR_DN  = 4'd12;
  localparam logic [3:0] KEY_MIN_DN   = 4'd13;
  localparam logic [3:0] KEY_SHOW_CLK = 4'd14;
  localparam logic [3:0] KEY_STOP     = 4'd15;

  // Segment patterns, active low, bit 7 is the dot.
  localparam logic [7:0] SEG_BLANK    = 8'hFF;
  localparam logic [7:0] SEG_DOT_MASK = 8'h7F;

  // One input item as it arrives.
  typedef struct packed {
    logic       command;
    logic [3:0] key_code;
  } csd_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] seg_digit7;
    logic [7:0] seg_digit6;
    logic [7:0] seg_digit5;
    logic [7:0] seg_digit4;
    logic [7:0] seg_digit3;
    logic [7:0] seg_digit2;
    logic [7:0] seg_digit1;
    logic [7:0] seg_digit0;
    logic       showing_stopwatch;
    logic       stopwatch_running;
  } csd_out_t;

  // Classified operation handed from the front to the back.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TICK,
    OP_HOUR_UP,
    OP_HOUR_DN,
    OP_MIN_UP,
    OP_MIN_DN,
    OP_SHOW_SW,
    OP_SHOW_CLK,
    OP_START,
    OP_STOP
  } csd_op_e;

  // Operation offered by the front queue.
  typedef struct packed {
    logic    valid;
    csd_op_e op;
  } csd_op_req_t;

endpackage

@@ rtl/core/csd_front.sv @@
// Front part: accepts input items, classifies them and queues the operations.
module csd_front import csd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  csd_in_t     item_i,
  output csd_op_req_t op_req_o,
  input  logic        op_ready_i
);

  csd_op_e    op_class;
  csd_op_e    op_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push_ok;
  logic       pop_ok;

  // Turn a tick or a key press into one operation.
  always_comb begin
    op_class = OP_NONE;
    if (item_i.command == CMD_TICK) begin
      op_class = OP_TICK;
    end else begin
      unique case (item_i.key_code)
        KEY_HOUR_UP:  op_class = OP_HOUR_UP;
        KEY_HOUR_DN:  op_class = OP_HOUR_DN;
        KEY_MIN_UP:   op_class = OP_MIN_UP;
        KEY_MIN_DN:   op_class = OP_MIN_DN;
        KEY_SHOW_SW:  op_class = OP_SHOW_SW;
        KEY_SHOW_CLK: op_class = OP_SHOW_CLK;
        KEY_START:    op_class = OP_START;
        KEY_STOP:     op_class = OP_STOP;
        default:      op_class = OP_NONE;
      endcase
    end
  end

  // Two-entry queue between the front and the back.
  assign full           = (cnt_q == 2'd2);
  assign push_ok        = push && !full;
  assign op_req_o.valid = (cnt_q != 2'd0);
  assign op_req_o.op    = op_q[rd_ptr_q];
  assign pop_ok         = op_req_o.valid && op_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_ok) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_ok) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      op_q[wr_ptr_q] <= op_class;
    end
  end

endmodule

@@ rtl/core/csd_back.sv @@
// Back part: clock and stopwatch state, display encoding and the result queue.
module csd_back import csd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  csd_op_req_t op_req_i,
  output logic        op_ready_o,
  output csd_out_t    result_o,
  output logic        empty,
  input  logic        pop
);

  // Seven-segment pattern of a decimal digit; codes above nine wrap mod ten.
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0, 4'd10: s = 8'hC0;
      4'd1, 4'd11: s = 8'hF9;
      4'd2, 4'd12: s = 8'hA4;
      4'd3, 4'd13: s = 8'hB0;
      4'd4, 4'd14: s = 8'h99;
      4'd5, 4'd15: s = 8'h92;
      4'd6:        s = 8'h82;
      4'd7:        s = 8'hF8;
      4'd8:        s = 8'h80;
      default:     s = 8'h90;
    endcase
    return s;
  endfunction

  // Tens digit of a value below sixty, by comparison.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    t = 4'd0;
    for (int unsigned i = 1; i < 6; i++) begin
      if (v >= 6'(i * 10)) begin
        t = 4'(i);
      end
    end
    return t;
  endfunction

  // Ones digit given the tens digit.
  function automatic logic [3:0] ones_of(input logic [5:0] v, input logic [3:0] t);
    logic [5:0] r;
    r = v - 6'({t, 3'b000} + {t, 1'b0});
    return r[3:0];
  endfunction

  logic [TickW-1:0] tick_q, tick_d;
  logic [5:0]       sec_q, sec_d;
  logic [5:0]       min_q, min_d;
  logic [4:0]       hour_q, hour_d;
  logic [31:0]      sw_q, sw_d;
  logic [31:0]      sw_inc;
  logic             mode_q, mode_d;
  logic             run_q, run_d;
  logic [TickW:0]   tick_sum;
  logic [7:0]       carry;
  logic             take;
  logic [3:0]       h_t, m_t, s_t;
  csd_out_t         res;

  csd_out_t         res_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop_ok;

  // The back takes an operation whenever the result queue has room.
  assign op_ready_o = (cnt_q != 2'd2);
  assign take       = op_req_i.valid && op_ready_o;

  // Stopwatch increment: a digit steps when every lower digit is nine.
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 1; i < 8; i++) begin
      carry[i] = carry[i-1] && (sw_q[4*(i-1) +: 4] >= 4'd9);
    end
    for (int i = 0; i < 8; i++) begin
      if (carry[i] && sw_q[4*i +: 4] >= 4'd9) begin
        sw_inc[4*i +: 4] = 4'd0;
      end else if (carry[i]) begin
        sw_inc[4*i +: 4] = sw_q[4*i +: 4] + 4'd1;
      end else begin
        sw_inc[4*i +: 4] = sw_q[4*i +: 4];
      end
    end
  end

  assign tick_sum = {1'b0, tick_q} + {{TickW{1'b0}}, 1'b1};

  // Next state for the operation being carried out.
  always_comb begin
    tick_d = tick_q;
    sec_d  = sec_q;
    min_d  = min_q;
    hour_d = hour_q;
    sw_d   = sw_q;
    mode_d = mode_q;
    run_d  = run_q;
    if (take) begin
      unique case (op_req_i.op)
        OP_TICK: begin
          if (run_q) begin
            sw_d = sw_inc;
          end
          if (tick_sum == (TickW + 1)'(TicksPerSecond)) begin
            tick_d = '0;
            if (sec_q >= 6'd59) begin
              sec_d = 6'd0;
              if (min_q >= 6'd59) begin
                min_d  = 6'd0;
                hour_d = (hour_q >= 5'd23) ? 5'd0 : hour_q + 5'd1;
              end else begin
                min_d = min_q + 6'd1;
              end
            end else begin
              sec_d = sec_q + 6'd1;
            end
          end else begin
            tick_d = tick_sum[TickW-1:0];
          end
        end
        OP_HOUR_UP:  hour_d = (hour_q >= 5'd23) ? 5'd0 : hour_q + 5'd1;
        OP_HOUR_DN:  hour_d = (hour_q == 5'd0 || hour_q > 5'd23) ? 5'd23 : hour_q - 5'd1;
        OP_MIN_UP:   min_d = (min_q >= 6'd59) ? 6'd0 : min_q + 6'd1;
        OP_MIN_DN:   min_d = (min_q == 6'd0 || min_q > 6'd59) ? 6'd59 : min_q - 6'd1;
        OP_SHOW_SW:  mode_d = 1'b1;
        OP_SHOW_CLK: mode_d = 1'b0;
        OP_START:    run_d = 1'b1;
        OP_STOP: begin
          if (run_q) begin
            run_d = 1'b0;
          end else begin
            sw_d = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Display encoding from the updated state.
  always_comb begin
    h_t = tens_of({1'b0, hour_d});
    m_t = tens_of(min_d);
    s_t = tens_of(sec_d);
    if (mode_d) begin
      res.seg_digit7 = seg_of(sw_d[31:28]);
      res.seg_digit6 = seg_of(sw_d[27:24]);
      res.seg_digit5 = seg_of(sw_d[23:20]);
      res.seg_digit4 = seg_of(sw_d[19:16]);
      res.seg_digit3 = seg_of(sw_d[15:12]);
      res.seg_digit2 = seg_of(sw_d[11:8]) & SEG_DOT_MASK;
      res.seg_digit1 = seg_of(sw_d[7:4]);
      res.seg_digit0 = seg_of(sw_d[3:0]);
    end else begin
      res.seg_digit7 = seg_of(h_t);
      res.seg_digit6 = seg_of(ones_of({1'b0, hour_d}, h_t));
      res.seg_digit5 = SEG_BLANK;
      res.seg_digit4 = seg_of(m_t);
      res.seg_digit3 = seg_of(ones_of(min_d, m_t));
      res.seg_digit2 = SEG_BLANK;
      res.seg_digit1 = seg_of(s_t);
      res.seg_digit0 = seg_of(ones_of(sec_d, s_t));
    end
    res.showing_stopwatch = mode_d;
    res.stopwatch_running = run_d;
  end

  // Clock and stopwatch state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      sec_q  <= SecondsReset;
      min_q  <= MinutesReset;
      hour_q <= HoursReset;
      sw_q   <= '0;
      mode_q <= 1'b1;
      run_q  <= 1'b1;
    end else begin
      tick_q <= tick_d;
      sec_q  <= sec_d;
      min_q  <= min_d;
      hour_q <= hour_d;
      sw_q   <= sw_d;
      mode_q <= mode_d;
      run_q  <= run_d;
    end
  end

  // Two-entry result queue toward the output side.
  assign empty    = (cnt_q == 2'd0);
  assign result_o = res_q[rd_ptr_q];
  assign pop_ok   = pop && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (take && !pop_ok) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_ok && !take) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (take) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_ok) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q[wr_ptr_q] <= res;
    end
  end

endmodule

@@ rtl/core/clock_stopwatch_display.sv @@
// Top level of the time-of-day clock and stopwatch with eight-digit display.
// A result passes through the operation queue and then the result queue.
// Throughput: one item per cycle unless pop stalls, set by the queues.
// Input and output each stall on their own; each queue holds two entries.
// Reset (asynchronous, active low) sets 23:59:45, stopwatch zero, running
// and shown, with both queues empty.
module clock_stopwatch_display import csd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  csd_in_t  item_i,
  output logic     empty,
  input  logic     pop,
  output csd_out_t result_o
);

  csd_op_req_t op_req;
  logic        op_ready;

  // Classification and operation queue.
  csd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .op_req_o   (op_req),
    .op_ready_i (op_ready)
  );

  // State update, display encoding and result queue.
  csd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_req_i   (op_req),
    .op_ready_o (op_ready),
    .result_o   (result_o),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

@@ tb/sv/clock_stopwatch_display_test.sv @@
// Self-checking testbench of the clock and stopwatch display block.
module clock_stopwatch_display_test;
  import csd_pkg::*;

  // Segment patterns of the decimal digits, active low.
  localparam logic [7:0] DIGIT_SEG [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam int unsigned ActiveItems = 1850;
  localparam int unsigned StuckLimit  = 400;
  localparam int unsigned DrainCycles = 8;

  // Tracks the clock, the stopwatch and the display, and holds the
  // display frames still owed by the block.
  class display_board;
    int unsigned  tick_count;
    logic [5:0]   seconds;
    logic [5:0]   minutes;
    logic [4:0]   hours;
    logic [31:0]  stopwatch_bcd;
    logic         show_stopwatch;
    logic         running;
    bit           midnight_seen;
    int unsigned  failures;
    csd_out_t     owed_frames[$];

    function new();
      tick_count     = 0;
      seconds        = SecondsReset;
      minutes        = MinutesReset;
      hours          = HoursReset;
      stopwatch_bcd  = '0;
      show_stopwatch = 1'b1;
      running        = 1'b1;
      midnight_seen  = 1'b0;
      failures       = 0;
    endfunction

    // Adds one to an eight-digit BCD count, wrapping at all nines.
    function logic [31:0] bcd_next(logic [31:0] v);
      for (int p = 0; p < 8; p++) begin
        if (v[4*p +: 4] < 4'd9) begin
          v[4*p +: 4] += 4'd1;
          return v;
        end
        v[4*p +: 4] = 4'd0;
      end
      return v;
    endfunction

    // Advances the time of day by one tick, with the full carry chain.
    function void advance_tick();
      if (running) stopwatch_bcd = bcd_next(stopwatch_bcd);
      tick_count++;
      if (tick_count >= TicksPerSecond) begin
        tick_count = 0;
        if (seconds >= 6'd59) begin
          seconds = '0;
          if (minutes >= 6'd59) begin
            minutes = '0;
            if (hours >= 5'd23) begin
              hours = '0;
              midnight_seen = 1'b1;
            end else begin
              hours++;
            end
          end else begin
            minutes++;
          end
        end else begin
          seconds++;
        end
      end
    endfunction

    // Applies one key press; keys below the hour key change nothing.
    function void apply_key(logic [3:0] key);
      case (key)
        KEY_HOUR_UP:  hours   = (hours >= 5'd23) ? 5'd0 : hours + 5'd1;
        KEY_HOUR_DN:  hours   = (hours == 5'd0 || hours > 5'd23) ? 5'd23 : hours - 5'd1;
        KEY_MIN_UP:   minutes = (minutes >= 6'd59) ? 6'd0 : minutes + 6'd1;
        KEY_MIN_DN:   minutes = (minutes == 6'd0 || minutes > 6'd59) ? 6'd59 : minutes - 6'd1;
        KEY_SHOW_SW:  show_stopwatch = 1'b1;
        KEY_SHOW_CLK: show_stopwatch = 1'b0;
        KEY_START:    running = 1'b1;
        KEY_STOP: begin
          // A second stop clears the paused count.
          if (running) running = 1'b0;
          else stopwatch_bcd = '0;
        end
        default: ;
      endcase
    endfunction

    // Builds the frame shown after the current state.
    function csd_out_t display_frame();
      csd_out_t   f;
      logic [7:0] d [8];
      if (show_stopwatch) begin
        for (int k = 0; k < 8; k++) d[k] = DIGIT_SEG[stopwatch_bcd[4*(7-k) +: 4] % 10];
        d[5] &= SEG_DOT_MASK;
      end else begin
        d[0] = DIGIT_SEG[hours / 10];
        d[1] = DIGIT_SEG[hours % 10];
        d[2] = SEG_BLANK;
        d[3] = DIGIT_SEG[minutes / 10];
        d[4] = DIGIT_SEG[minutes % 10];
        d[5] = SEG_BLANK;
        d[6] = DIGIT_SEG[seconds / 10];
        d[7] = DIGIT_SEG[seconds % 10];
      end
      f.seg_digit7 = d[0];
      f.seg_digit6 = d[1];
      f.seg_digit5 = d[2];
      f.seg_digit4 = d[3];
      f.seg_digit3 = d[4];
      f.seg_digit2 = d[5];
      f.seg_digit1 = d[6];
      f.seg_digit0 = d[7];
      f.showing_stopwatch = show_stopwatch;
      f.stopwatch_running = running;
      return f;
    endfunction

    // Called on each input transfer.
    function void note_item(csd_in_t it);
      if (it.command == CMD_TICK) advance_tick();
      else apply_key(it.key_code);
      owed_frames.push_back(display_frame());
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        failures++;
      end
    endfunction

    // Called on each result transfer.
    function void check_frame(csd_out_t got);
      csd_out_t want;
      if (owed_frames.size() == 0) begin
        $error("result transfer with no frame owed: %h", got);
        failures++;
        return;
      end
      want = owed_frames.pop_front();
      compare_field("seg_digit7", want.seg_digit7, got.seg_digit7);
      compare_field("seg_digit6", want.seg_digit6, got.seg_digit6);
      compare_field("seg_digit5", want.seg_digit5, got.seg_digit5);
      compare_field("seg_digit4", want.seg_digit4, got.seg_digit4);
      compare_field("seg_digit3", want.seg_digit3, got.seg_digit3);
      compare_field("seg_digit2", want.seg_digit2, got.seg_digit2);
      compare_field("seg_digit1", want.seg_digit1, got.seg_digit1);
      compare_field("seg_digit0", want.seg_digit0, got.seg_digit0);
      compare_field("showing_stopwatch", want.showing_stopwatch, got.showing_stopwatch);
      compare_field("stopwatch_running", want.stopwatch_running, got.stopwatch_running);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  csd_in_t  item = '0;
  csd_out_t result;

  display_board board = new();
  int unsigned  active_items = 0;
  int unsigned  stuck_cycles = 0;
  bit           send_calm = 1'b0;

  clock_stopwatch_display dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item),
    .empty    (empty),
    .pop      (pop),
    .result_o (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item until its transfer, then idles for a random gap.
  // Starts and ends at a falling edge.
  task automatic send_item(csd_in_t it);
    int gap;
    item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    if (it.command == CMD_TICK || it.key_code >= KEY_HOUR_UP) active_items++;
    @(negedge clk);
    if ($urandom_range(0, 99) == 0) send_calm = !send_calm;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_tick();
    csd_in_t it;
    it.command  = CMD_TICK;
    it.key_code = 4'($urandom_range(0, 15));
    send_item(it);
  endtask

  task automatic send_key(logic [3:0] key);
    csd_in_t it;
    it.command  = CMD_KEY;
    it.key_code = key;
    send_item(it);
  endtask

  // Time keys before the first midnight come as a step and its undo, so
  // the clock still reaches 23:59:59 and carries through every digit.
  task automatic send_random_key();
    logic [3:0] key;
    key = 4'($urandom_range(0, 15));
    send_key(key);
    if (!board.midnight_seen) begin
      case (key)
        KEY_HOUR_UP: send_key(KEY_HOUR_DN);
        KEY_HOUR_DN: send_key(KEY_HOUR_UP);
        KEY_MIN_UP:  send_key(KEY_MIN_DN);
        KEY_MIN_DN:  send_key(KEY_MIN_UP);
        default: ;
      endcase
    end
  endtask

  // Result side: pop with random stalls.
  initial begin : result_drain
    int  stall;
    bit  calm;
    stall = 0;
    calm  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 99) == 0) calm = !calm;
        stall = pick_gap(calm);
      end
    end
  end

  // Every transfer in either direction goes to the board; a long stretch
  // with no transfer at all ends the run.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (push && !full) board.note_item(item);
      if (pop && !empty) board.check_frame(result);
      if ((push && !full) || (pop && !empty)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= StuckLimit) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Ignored keys, including all-zero and all-ones in the low bits.
    send_key(4'd0);
    send_key(4'd7);
    send_key(4'd3);
    // Hour and minute keys across their wraps, then back to 23:59.
    send_key(KEY_HOUR_UP);
    send_key(KEY_HOUR_DN);
    send_key(KEY_MIN_UP);
    send_key(KEY_MIN_DN);
    send_key(KEY_HOUR_DN);
    send_key(KEY_HOUR_UP);
    send_key(KEY_MIN_DN);
    send_key(KEY_MIN_UP);
    // Clock display for a couple of ticks.
    send_key(KEY_SHOW_CLK);
    send_tick();
    send_tick();
    send_key(KEY_SHOW_SW);
    // Stop, tick while paused, clear, start, and start while running.
    send_key(KEY_STOP);
    send_tick();
    send_key(KEY_STOP);
    send_key(KEY_START);
    send_key(KEY_START);
    send_tick();

    // Mostly ticks, so the clock runs through midnight.
    while (active_items < ActiveItems || !board.midnight_seen) begin
      if ($urandom_range(0, 99) < 88) send_tick();
      else send_random_key();
    end
    push <= 1'b0;

    while (board.owed_frames.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (board.failures == 0 && board.owed_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/csd_pkg.sv
rtl/core/csd_front.sv
rtl/core/csd_back.sv
rtl/core/clock_stopwatch_display.sv
tb/sv/clock_stopwatch_display_test.sv
